/* rtl/fms_pkg.sv */
// Shared constants, types and character helpers for the fuzzy match scorer.
// No dependencies; used by the top level, the checker and the testbench.
package fms_pkg;

  localparam int MAX_LINE  = 256;
  localparam int MAX_QUERY = 16;
  localparam int ADDR_W    = $clog2(MAX_LINE);
  localparam int CNT_W     = $clog2(MAX_LINE + 1);
  localparam int QLEN_W    = 5;
  localparam int QIDX_W    = $clog2(MAX_QUERY);
  localparam int SCORE_W   = 16;
  localparam int POS_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_HIGH   = 2'd2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic [1:0] {
    RUN_NONE     = 2'd0,
    RUN_ADJACENT = 2'd1,
    RUN_BOUNDARY = 2'd2
  } run_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_OREAD = 6'b000010,
    ST_OCHK  = 6'b000100,
    ST_IREAD = 6'b001000,
    ST_ICHK  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

/* rtl/fuzzy_match_scorer_top.sv */
// Fuzzy match scorer top level: line buffer, scan sequencer and result register.
// Depends on fms_pkg and fms_ram.
//
// Line bytes are taken one per cycle while in the idle state and written to a
// 256-byte line RAM; bytes past 256 are dropped. The transfer that carries
// end_of_line starts the scan, during which no input is taken. The sequencer
// reads the line RAM through a read state and a check state for each byte
// (registered read): it walks the line for the first query character and, from
// each start found, scans forward for the rest of the query; a start whose
// search runs off the end of the line ends the scan. An empty query goes from
// the end_of_line transfer straight to the done state, which posts the result.
// The result waits in an output register while the next line loads.
module fuzzy_match_scorer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fms_pkg::CFG_DW-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_line_char,
  input  logic                           in_end_of_line,
  input  logic                           in_no_char,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_matched,
  output logic [fms_pkg::SCORE_W-1:0]    out_points,
  output logic [fms_pkg::POS_W-1:0]      out_first_pos,
  output logic [fms_pkg::POS_W-1:0]      out_last_pos
);

  localparam int CW = fms_pkg::CNT_W;
  localparam int AW = fms_pkg::ADDR_W;
  localparam int SW = fms_pkg::SCORE_W;
  localparam int PW = fms_pkg::POS_W;
  localparam int QW = fms_pkg::QIDX_W;
  localparam int LW = fms_pkg::QLEN_W;

  fms_pkg::state_t state_r, state_nxt;
  fms_pkg::run_t   run_r, run_nxt;

  logic [LW-1:0]  qlen_r, qlen_nxt;
  logic [63:0]    qlow_r, qlow_nxt;
  logic [63:0]    qhigh_r, qhigh_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [CW-1:0]  prev_r, prev_nxt;
  logic [QW-1:0]  k_r, k_nxt;
  logic [SW-1:0]  score_r, score_nxt;
  logic [7:0]     last_byte_r, last_byte_nxt;
  logic           found_r, found_nxt;
  logic [SW-1:0]  best_r, best_nxt;
  logic [CW-1:0]  first_r, first_nxt;
  logic [CW-1:0]  last_r, last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_matched_r, out_matched_nxt;
  logic [SW-1:0]  out_points_r, out_points_nxt;
  logic [PW-1:0]  out_first_r, out_first_nxt;
  logic [PW-1:0]  out_last_r, out_last_nxt;

  logic           in_xfer;
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [LW-1:0]  qlen_eff;
  logic [127:0]   q_all;
  logic [7:0]     head_char;
  logic [7:0]     k_char;
  logic [7:0]     rd_fold;
  logic [CW-1:0]  gap_len;
  logic [SW:0]    score_sum;
  logic [SW-1:0]  score_hit;
  logic           k_last;

  assign in_ready = (state_r == fms_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign ram_we   = in_xfer && !in_no_char && (count_r < CW'(fms_pkg::MAX_LINE));

  assign ram_raddr = (state_r == fms_pkg::ST_OREAD) ? i_r[AW-1:0] : j_r[AW-1:0];

  fms_ram #(
    .WIDTH (8),
    .DEPTH (fms_pkg::MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_line_char),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign qlen_eff  = (qlen_r > LW'(fms_pkg::MAX_QUERY)) ? LW'(fms_pkg::MAX_QUERY) : qlen_r;
  assign q_all     = {qhigh_r, qlow_r};
  assign head_char = fms_pkg::fold(qlow_r[7:0]);
  assign k_char    = fms_pkg::fold(q_all[{k_r, 3'b000} +: 8]);
  assign rd_fold   = fms_pkg::fold(ram_rdata);
  assign k_last    = (LW'(k_r) + LW'(1)) == qlen_eff;
  assign gap_len   = j_r - prev_r;

  always_comb begin
    score_sum = (SW + 1)'(score_r) + (SW + 1)'(gap_len);
    if (j_r == prev_r + CW'(1)) begin
      score_sum = (SW + 1)'(score_r) + (SW + 1)'(run_r != fms_pkg::RUN_ADJACENT);
    end else if (!fms_pkg::is_alnum(last_byte_r)) begin
      score_sum = (SW + 1)'(score_r) + (SW + 1)'(run_r != fms_pkg::RUN_BOUNDARY);
    end
    score_hit = score_sum[SW] ? fms_pkg::SCORE_MAX : score_sum[SW-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    run_nxt         = run_r;
    qlen_nxt        = qlen_r;
    qlow_nxt        = qlow_r;
    qhigh_nxt       = qhigh_r;
    count_nxt       = count_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    prev_nxt        = prev_r;
    k_nxt           = k_r;
    score_nxt       = score_r;
    last_byte_nxt   = last_byte_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    first_nxt       = first_r;
    last_nxt        = last_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    out_points_nxt  = out_points_r;
    out_first_nxt   = out_first_r;
    out_last_nxt    = out_last_r;

    if (cfg_we) begin
      case (cfg_index)
        fms_pkg::REG_QUERY_LENGTH: qlen_nxt  = cfg_wdata[LW-1:0];
        fms_pkg::REG_QUERY_LOW:    qlow_nxt  = cfg_wdata;
        fms_pkg::REG_QUERY_HIGH:   qhigh_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      fms_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (ram_we) begin
            count_nxt = count_r + CW'(1);
          end
          if (in_end_of_line) begin
            i_nxt     = '0;
            first_nxt = '0;
            last_nxt  = '0;
            if (qlen_eff == '0) begin
              found_nxt = 1'b1;
              best_nxt  = fms_pkg::SCORE_MAX;
              state_nxt = fms_pkg::ST_DONE;
            end else begin
              found_nxt = 1'b0;
              best_nxt  = '0;
              state_nxt = fms_pkg::ST_OREAD;
            end
          end
        end
      end
      fms_pkg::ST_OREAD: begin
        state_nxt = (i_r < count_r) ? fms_pkg::ST_OCHK : fms_pkg::ST_DONE;
      end
      fms_pkg::ST_OCHK: begin
        if (rd_fold == head_char) begin
          if (qlen_eff == LW'(1)) begin
            found_nxt = 1'b1;
            best_nxt  = SW'(1);
            first_nxt = i_r;
            last_nxt  = i_r;
            state_nxt = fms_pkg::ST_DONE;
          end else begin
            prev_nxt      = i_r;
            j_nxt         = i_r + CW'(1);
            k_nxt         = QW'(1);
            score_nxt     = SW'(1);
            run_nxt       = fms_pkg::RUN_NONE;
            last_byte_nxt = ram_rdata;
            state_nxt     = fms_pkg::ST_IREAD;
          end
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = fms_pkg::ST_OREAD;
        end
      end
      fms_pkg::ST_IREAD: begin
        // a failed search from this start fails from every later start
        state_nxt = (j_r < count_r) ? fms_pkg::ST_ICHK : fms_pkg::ST_DONE;
      end
      fms_pkg::ST_ICHK: begin
        last_byte_nxt = ram_rdata;
        j_nxt         = j_r + CW'(1);
        state_nxt     = fms_pkg::ST_IREAD;
        if (rd_fold == k_char) begin
          if (j_r == prev_r + CW'(1)) begin
            run_nxt = fms_pkg::RUN_ADJACENT;
          end else if (!fms_pkg::is_alnum(last_byte_r)) begin
            run_nxt = fms_pkg::RUN_BOUNDARY;
          end else begin
            run_nxt = fms_pkg::RUN_NONE;
          end
          score_nxt = score_hit;
          prev_nxt  = j_r;
          k_nxt     = k_r + QW'(1);
          if (k_last) begin
            if (!found_r || score_hit < best_r) begin
              best_nxt  = score_hit;
              first_nxt = i_r;
              last_nxt  = j_r;
            end
            found_nxt = 1'b1;
            i_nxt     = i_r + CW'(1);
            state_nxt = fms_pkg::ST_OREAD;
          end
        end
      end
      fms_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = found_r;
          out_points_nxt  = found_r ? best_r : '0;
          out_first_nxt   = found_r ? first_r[PW-1:0] : '0;
          out_last_nxt    = found_r ? last_r[PW-1:0] : '0;
          count_nxt       = '0;
          state_nxt       = fms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fms_pkg::ST_IDLE;
      qlen_r      <= '0;
      qlow_r      <= '0;
      qhigh_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qlen_r      <= qlen_nxt;
      qlow_r      <= qlow_nxt;
      qhigh_r     <= qhigh_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r         <= run_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    prev_r        <= prev_nxt;
    k_r           <= k_nxt;
    score_r       <= score_nxt;
    last_byte_r   <= last_byte_nxt;
    found_r       <= found_nxt;
    best_r        <= best_nxt;
    first_r       <= first_nxt;
    last_r        <= last_nxt;
    out_matched_r <= out_matched_nxt;
    out_points_r  <= out_points_nxt;
    out_first_r   <= out_first_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_matched   = out_matched_r;
  assign out_points    = out_points_r;
  assign out_first_pos = out_first_r;
  assign out_last_pos  = out_last_r;

endmodule

/* rtl/fms_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fms_checker.sv */
// Port-level checks for the fuzzy match scorer, bound to the top level.
// Depends on fms_pkg and fuzzy_match_scorer_top.
module fms_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_matched,
  input logic [fms_pkg::SCORE_W-1:0]   out_points,
  input logic [fms_pkg::POS_W-1:0]     out_first_pos,
  input logic [fms_pkg::POS_W-1:0]     out_last_pos
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_points) && $stable(out_matched))
    else $error("result dropped or changed while stalled");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_points == '0 && out_first_pos == '0 &&
    out_last_pos == '0)
    else $error("unmatched result carries nonzero fields");

  a_match_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_points != '0 && out_last_pos >= out_first_pos)
    else $error("matched result has zero score or ends before it starts");

  a_single_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched && out_points == 16'd1 |-> out_last_pos == out_first_pos)
    else $error("score of one spans more than one position");

endmodule

bind fuzzy_match_scorer_top fms_checker u_fms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_matched   (out_matched),
  .out_points    (out_points),
  .out_first_pos (out_first_pos),
  .out_last_pos  (out_last_pos)
);

/* dv/fuzzy_match_scorer_top_tb.sv */
// Self-checking testbench for fuzzy_match_scorer_top: drives candidate lines against
// configured queries and compares every score with a behavioral scorer kept in step here.
// Depends on fms_pkg and the RTL of the block only.
module fuzzy_match_scorer_top_tb;

  localparam logic [fms_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic                        matched;
    logic [fms_pkg::SCORE_W-1:0] points;
    logic [fms_pkg::POS_W-1:0]   first_pos;
    logic [fms_pkg::POS_W-1:0]   last_pos;
  } score_rec_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [fms_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fms_pkg::CFG_DW-1:0]    cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_line_char;
  logic                          in_end_of_line;
  logic                          in_no_char;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_matched;
  logic [fms_pkg::SCORE_W-1:0]   out_points;
  logic [fms_pkg::POS_W-1:0]     out_first_pos;
  logic [fms_pkg::POS_W-1:0]     out_last_pos;

  logic [fms_pkg::QLEN_W-1:0] q_len;
  logic [63:0]                q_low;
  logic [63:0]                q_high;
  logic [7:0]                 line_buf [fms_pkg::MAX_LINE];
  int                         line_len;

  score_rec_t pending_scores[$];
  score_rec_t oldest;
  logic [7:0] line_bytes[$];

  bit in_live;
  bit calm;
  int out_hold;
  int errors;
  int items_done;
  int lines_done;
  int results_seen;
  int matches_seen;

  fuzzy_match_scorer_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_line_char  (in_line_char),
    .in_end_of_line(in_end_of_line),
    .in_no_char    (in_no_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_matched   (out_matched),
    .out_points    (out_points),
    .out_first_pos (out_first_pos),
    .out_last_pos  (out_last_pos)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] query_byte(input int k);
    if (k < 8) begin
      return lower_case(q_low[8*k +: 8]);
    end
    return lower_case(q_high[8*(k-8) +: 8]);
  endfunction

  function automatic int find_next(input int from, input logic [7:0] ch);
    int i;
    for (i = from; i < line_len; i++) begin
      if (lower_case(line_buf[i]) == ch) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic score_rec_t score_line();
    score_rec_t    r;
    int            qn, at, prev, nxt, pts, best, first, last, k;
    bit            ok, found;
    logic [7:0]    head;
    fms_pkg::run_t run;
    r = '0;
    qn = (int'(q_len) > fms_pkg::MAX_QUERY) ? fms_pkg::MAX_QUERY : int'(q_len);
    found = 1'b0;
    best = 0;
    first = 0;
    last = 0;
    if (qn == 0) begin
      found = 1'b1;
      best = 65535;
    end else if (qn == 1) begin
      at = find_next(0, query_byte(0));
      if (at >= 0) begin
        found = 1'b1;
        best = 1;
        first = at;
        last = at;
      end
    end else begin
      head = query_byte(0);
      for (at = 0; at < line_len; at++) begin
        if (lower_case(line_buf[at]) != head) continue;
        ok = 1'b1;
        prev = at;
        pts = 1;
        run = fms_pkg::RUN_NONE;
        for (k = 1; k < qn && ok; k++) begin
          nxt = find_next(prev + 1, query_byte(k));
          if (nxt < 0) begin
            ok = 1'b0;
          end else begin
            if (nxt == prev + 1) begin
              if (run != fms_pkg::RUN_ADJACENT) begin
                run = fms_pkg::RUN_ADJACENT;
                pts = pts + 1;
              end
            end else if (!word_char(line_buf[nxt-1])) begin
              if (run != fms_pkg::RUN_BOUNDARY) begin
                run = fms_pkg::RUN_BOUNDARY;
                pts = pts + 1;
              end
            end else begin
              run = fms_pkg::RUN_NONE;
              pts = pts + (nxt - prev);
            end
            if (pts > 65535) pts = 65535;
            prev = nxt;
          end
        end
        if (ok && (!found || pts < best)) begin
          best = pts;
          first = at;
          last = prev;
        end
        if (ok) found = 1'b1;
      end
    end
    if (found) begin
      r.matched = 1'b1;
      r.points = best[fms_pkg::SCORE_W-1:0];
      r.first_pos = first[fms_pkg::POS_W-1:0];
      r.last_pos = last[fms_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  function automatic void note_item(input logic [7:0] ch, input logic eol, input logic none);
    if (!none && line_len < fms_pkg::MAX_LINE) begin
      line_buf[line_len] = ch;
      line_len++;
    end
    items_done++;
    if (eol) begin
      pending_scores.push_back(score_line());
      line_len = 0;
      lines_done++;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [7:0] pick_char();
    string pool;
    pool = "abcxABCX09 _-.";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result: matched %0d points %0d first_pos %0d last_pos %0d",
               out_matched, out_points, out_first_pos, out_last_pos);
        errors++;
      end else begin
        oldest = pending_scores.pop_front();
        results_seen++;
        if (oldest.matched) matches_seen++;
        check_field("matched", oldest.matched, out_matched);
        check_field("points", oldest.points, out_points);
        check_field("first_pos", oldest.first_pos, out_first_pos);
        check_field("last_pos", oldest.last_pos, out_last_pos);
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      out_hold = $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic idle_in();
    if (in_live) in_valid <= 1'b0;
    in_live = 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] ch, input logic eol, input logic none);
    if (!calm && $urandom_range(0, 9) == 0) begin
      idle_in();
      repeat ($urandom_range(0, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_char <= ch;
    in_end_of_line <= eol;
    in_no_char <= none;
    in_live = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    note_item(ch, eol, none);
  endtask

  task automatic send_line(input bit close_empty);
    int i;
    for (i = 0; i < line_bytes.size(); i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b1);
      send_item(line_bytes[i], (i == line_bytes.size() - 1) && !close_empty, 1'b0);
    end
    if (close_empty || line_bytes.size() == 0) send_item(8'($urandom), 1'b1, 1'b1);
    line_bytes.delete();
  endtask

  task automatic text_line(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic hold_for_results();
    idle_in();
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  task automatic load_query(input int n, input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] len_word;
    hold_for_results();
    repeat (8) @(posedge clk);
    len_word = {$urandom, $urandom};
    len_word[fms_pkg::QLEN_W-1:0] = n[fms_pkg::QLEN_W-1:0];
    cfg_we <= 1'b1;
    cfg_index <= fms_pkg::REG_QUERY_LENGTH;
    cfg_wdata <= len_word;
    @(posedge clk);
    cfg_index <= fms_pkg::REG_QUERY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= fms_pkg::REG_QUERY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= REG_UNMAPPED;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    q_len = len_word[fms_pkg::QLEN_W-1:0];
    q_low = lo;
    q_high = hi;
    @(posedge clk);
  endtask

  task automatic query_text(input string s);
    logic [63:0] lo, hi;
    int          k;
    lo = '0;
    hi = '0;
    for (k = 0; k < s.len() && k < fms_pkg::MAX_QUERY; k++) begin
      if (k < 8) lo[8*k +: 8] = s[k];
      else hi[8*(k-8) +: 8] = s[k];
    end
    load_query(s.len(), lo, hi);
  endtask

  task automatic test_directed();
    query_text("");
    text_line("Ab");
    send_line(1'b0);
    send_line(1'b1);
    query_text("K");
    text_line("xkK");
    send_line(1'b0);
    text_line("zz");
    send_line(1'b1);
    query_text("aB");
    text_line("a-b ab");
    send_line(1'b0);
    query_text("ac");
    text_line("abc");
    send_line(1'b0);
    load_query(2, 64'hFF00, '0);
    line_bytes = {8'h00, 8'hFF};
    send_line(1'b0);
    query_text("aa");
    text_line("a");
    send_line(1'b0);
    text_line("xaa");
    send_line(1'b0);
  endtask

  task automatic test_long_lines();
    load_query(31, '1, '1);
    repeat (20) line_bytes.push_back(8'hFF);
    send_line(1'b0);
    load_query(fms_pkg::MAX_QUERY, '0, '0);
    line_bytes.push_back(8'h41);
    repeat (16) line_bytes.push_back(8'h00);
    send_line(1'b0);
    query_text("xy");
    repeat (254) line_bytes.push_back(".");
    text_line("xYyy");
    send_line(1'b0);
    repeat (250) line_bytes.push_back(".");
    text_line("x.......y.");
    send_line(1'b1);
  endtask

  task automatic run_random_phase(input int n_lines);
    int          qn, i, k, drop;
    logic [63:0] lo, hi;
    logic [7:0]  c;
    case ($urandom_range(0, 19))
      0, 1: qn = 0;
      2, 3: qn = 1;
      4: qn = $urandom_range(7, 16);
      5: qn = $urandom_range(17, 31);
      default: qn = $urandom_range(2, 6);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
    end else begin
      for (k = 0; k < 16; k++) begin
        c = pick_char();
        if (k < 8) lo[8*k +: 8] = c;
        else hi[8*(k-8) +: 8] = c;
      end
    end
    load_query(qn, lo, hi);
    for (i = 0; i < n_lines; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(0, 12)) begin
          line_bytes.push_back($urandom_range(0, 1) ? 8'($urandom) : pick_char());
        end
      end else begin
        drop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : -1;
        for (k = 0; k < qn && k < fms_pkg::MAX_QUERY; k++) begin
          repeat ($urandom_range(0, 3)) line_bytes.push_back(pick_char());
          if (k != drop) line_bytes.push_back(mixed_case(query_byte(k)));
        end
        repeat ($urandom_range(0, 3)) line_bytes.push_back(pick_char());
      end
      send_line($urandom_range(0, 5) == 0);
      if (!calm && $urandom_range(0, 15) == 0) hold_for_results();
    end
  endtask

  task automatic test_random_queries();
    repeat (5) run_random_phase(14);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    run_random_phase(14);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = fms_pkg::REG_QUERY_LENGTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_line_char = '0;
    in_end_of_line = 1'b0;
    in_no_char = 1'b0;
    q_len = '0;
    q_low = '0;
    q_high = '0;
    line_len = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_lines();
    test_random_queries();
    test_back_to_back();
    hold_for_results();
    repeat (200) @(posedge clk);
    $display("Scored %0d lines from %0d input transfers; %0d of %0d results matched.",
             lines_done, items_done, matches_seen, results_seen);
    $display("Queries ran from empty to over-long, with folded case, 0x00/0xFF bytes,");
    $display("runs and overflow lines.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
